/* sv/assert_macros.svh */
// assertion macros used by the port-level checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is high
`define AC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define AC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/aesctr_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and aes round functions for the ctr-mode cipher
// no dependencies
package aesctr_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int POS_W = $clog2(BLOCK_BYTES);
  localparam int RK_ENTRIES = 15;
  localparam int RK_AW = $clog2(RK_ENTRIES);
  localparam int RK_WIDTH = 128;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW = 3'd6;

  // key size codes, the reserved code runs as 256-bit
  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;

  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;
  } q_item_t;

  typedef struct packed {
    logic [1:0]   key_size;
    logic [255:0] key;
    logic [127:0] iv;
  } cfg_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_EXPAND,
    ENG_ENCRYPT
  } eng_state_t;

  typedef struct packed {
    logic idle;
    logic kx_run;
    logic enc_run;
  } eng_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // subbytes, shiftrows and (unless final) mixcolumns; byte 0 sits in the top bits
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      b[i] = sbox(s[127-8*i -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[4*c+i] = b[4*((c+i)%4)+i];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      x = a0 ^ a1 ^ a2 ^ a3;
      if (final_rnd) begin
        r[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127-32*c -: 32] = {a0 ^ x ^ xtime(a0 ^ a1), a1 ^ x ^ xtime(a1 ^ a2),
                             a2 ^ x ^ xtime(a2 ^ a3), a3 ^ x ^ xtime(a3 ^ a0)};
      end
    end
    return r;
  endfunction

endpackage

/* sv/aes_ctr_stream_cipher_top.sv */
`timescale 1ns / 1ps
//  channel | signals                          | direction
//  in      | in_valid, in_ready, in_data      | byte and last flag into the block
//  out     | out_valid, out_ready, out_data   | byte xor keystream, last flag
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes, always ready
// first byte of a message waits for key expansion and one block encryption in the shared
// round unit; after that one byte per cycle unless the output stalls or the queue is empty:
// the next keystream block is encrypted while 16 bytes stream
// output register holds a result under stall; the input queue takes bytes until full
// reset clears control state; the round key ram is rewritten at every message start
module aes_ctr_stream_cipher_top import aesctr_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [1:0]            key_size;
  logic [CFG_DATA_W-1:0] key_word0, key_word1, key_word2, key_word3, iv_high, iv_low;
  cfg_t                  cfg;
  logic                  q_valid, q_pop;
  q_item_t               q_head;

  assign cfg_ready = 1'b1;
  assign cfg = '{key_size: key_size, key: {key_word0, key_word1, key_word2, key_word3},
                 iv: {iv_high, iv_low}};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size  <= KEY_128;
      key_word0 <= '0;
      key_word1 <= '0;
      key_word2 <= '0;
      key_word3 <= '0;
      iv_high   <= '0;
      iv_low    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_SIZE:  key_size  <= cfg_data[1:0];
        REG_KEY_WORD0: key_word0 <= cfg_data;
        REG_KEY_WORD1: key_word1 <= cfg_data;
        REG_KEY_WORD2: key_word2 <= cfg_data;
        REG_KEY_WORD3: key_word3 <= cfg_data;
        REG_IV_HIGH:   iv_high   <= cfg_data;
        REG_IV_LOW:    iv_low    <= cfg_data;
        default: ;
      endcase
    end
  end

  aesctr_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  aesctr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* sv/aesctr_ram.sv */
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module aesctr_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/aesctr_front.sv */
`timescale 1ns / 1ps
// input side: accepts bytes, marks the first byte of each message, queues them
// depends on aesctr_pkg
module aesctr_front import aesctr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_pop,
  output q_item_t  q_head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t           slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              open;
  logic              push;

  assign in_ready = (count != CNT_W'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_head   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{data: in_data.data_in, last: in_data.last_in, first: !open};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      open   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
        open   <= !in_data.last_in;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, q_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/aesctr_back.sv */
`timescale 1ns / 1ps
// execution side: key expansion, iterative aes round unit, keystream buffers, output register
// depends on aesctr_pkg and aesctr_ram
module aesctr_back import aesctr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_item_t   q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  eng_state_t state, state_next;
  eng_ctl_t   ctl;

  logic               started;
  logic [2:0]         nk_m1;
  logic [3:0]         rounds;
  logic [127:0]       ctr;
  logic [POS_W-1:0]   pos;
  logic               cur_valid, nxt_valid, cur_valid_next, nxt_valid_next;
  logic [127:0]       cur_blk, nxt_blk, cur_blk_next, nxt_blk_next;

  // key expansion
  logic [5:0]         kx_i;
  logic [2:0]         kx_j;
  logic [7:0]         rc;
  logic [31:0]        win [8];
  logic [31:0]        grp [3];
  logic [31:0]        key_words [8];
  logic [31:0]        kx_t, kx_word;
  logic               kx_done;

  // round unit
  logic [3:0]         enc_rnd;
  logic [127:0]       blk, ks_new;
  logic               enc_done;

  logic               rk_we;
  logic [RK_AW-1:0]   rk_waddr, rk_raddr;
  logic [RK_WIDTH-1:0] rk_wdata, rk_rdata;

  logic               start_msg, pop, abort, wrap;
  logic [7:0]         cur_bytes [BLOCK_BYTES];

  aesctr_ram #(.WIDTH(RK_WIDTH), .DEPTH(RK_ENTRIES)) u_rk_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (rk_waddr),
    .wdata (rk_wdata),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

  always_comb begin
    ctl.idle    = (state == ENG_IDLE);
    ctl.kx_run  = (state == ENG_EXPAND);
    ctl.enc_run = (state == ENG_ENCRYPT);
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_words[i] = cfg.key[255-32*i -: 32];
    end
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      cur_bytes[i] = cur_blk[127-8*i -: 8];
    end
  end

  // next key schedule word
  always_comb begin
    kx_t = win[0];
    if (kx_j == 3'd0) begin
      kx_t = {sbox(win[0][23:16]) ^ rc, sbox(win[0][15:8]), sbox(win[0][7:0]),
              sbox(win[0][31:24])};
    end else if (nk_m1 == 3'd7 && kx_j == 3'd4) begin
      kx_t = sub_word(win[0]);
    end
    kx_word = (kx_i <= {3'b000, nk_m1}) ? key_words[kx_i[2:0]] : (win[nk_m1] ^ kx_t);
  end

  assign kx_done  = ctl.kx_run && (kx_i == {rounds, 2'b11});
  assign rk_we    = ctl.kx_run && (kx_i[1:0] == 2'b11);
  assign rk_waddr = kx_i[5:2];
  assign rk_wdata = {grp[0], grp[1], grp[2], kx_word};
  // round key for the next cycle; park on round 0 so a new block can start at once
  assign rk_raddr = (ctl.enc_run && enc_rnd != rounds) ? RK_AW'(enc_rnd + 4'd1) : '0;

  assign enc_done = ctl.enc_run && (enc_rnd == rounds);
  assign ks_new   = aes_round(blk, enc_rnd == rounds) ^ rk_rdata;

  assign start_msg = ctl.idle && !started && q_valid && q_head.first;
  assign pop       = q_valid && started && cur_valid && (!out_valid || out_ready);
  assign abort     = pop && q_head.last;
  assign wrap      = pop && (pos == POS_W'(BLOCK_BYTES - 1));
  assign q_pop     = pop;

  // keystream buffer update
  always_comb begin
    cur_blk_next   = cur_blk;
    nxt_blk_next   = nxt_blk;
    cur_valid_next = cur_valid;
    nxt_valid_next = nxt_valid;
    if (wrap) begin
      cur_blk_next   = nxt_blk;
      cur_valid_next = nxt_valid;
      nxt_valid_next = 1'b0;
    end
    if (enc_done) begin
      if (!cur_valid_next) begin
        cur_blk_next   = ks_new;
        cur_valid_next = 1'b1;
      end else begin
        nxt_blk_next   = ks_new;
        nxt_valid_next = 1'b1;
      end
    end
    if (abort) begin
      cur_valid_next = 1'b0;
      nxt_valid_next = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ENG_IDLE: begin
        if (start_msg) begin
          state_next = ENG_EXPAND;
        end else if (started && !nxt_valid_next && !abort) begin
          state_next = ENG_ENCRYPT;
        end
      end
      ENG_EXPAND: begin
        if (kx_done) begin
          state_next = ENG_ENCRYPT;
        end
      end
      ENG_ENCRYPT: begin
        if (abort || (enc_done && nxt_valid_next)) begin
          state_next = ENG_IDLE;
        end
      end
      default: state_next = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ENG_IDLE;
      started   <= 1'b0;
      cur_valid <= 1'b0;
      nxt_valid <= 1'b0;
      pos       <= '0;
      enc_rnd   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_valid <= cur_valid_next;
      nxt_valid <= nxt_valid_next;
      if (start_msg) begin
        started <= 1'b1;
      end else if (abort) begin
        started <= 1'b0;
      end
      if (abort) begin
        pos <= '0;
      end else if (pop) begin
        pos <= pos + POS_W'(1);
      end
      enc_rnd <= (ctl.enc_run && !enc_done && !abort) ? enc_rnd + 4'd1 : 4'd0;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_blk <= cur_blk_next;
    nxt_blk <= nxt_blk_next;
    if (pop) begin
      out_data <= '{data_out: q_head.data ^ cur_bytes[pos], last_out: q_head.last};
    end
    if (start_msg) begin
      kx_i <= '0;
      kx_j <= '0;
      rc   <= 8'h01;
      ctr  <= cfg.iv;
      case (cfg.key_size)
        KEY_128: begin
          nk_m1  <= 3'd3;
          rounds <= 4'd10;
        end
        KEY_192: begin
          nk_m1  <= 3'd5;
          rounds <= 4'd12;
        end
        default: begin
          nk_m1  <= 3'd7;
          rounds <= 4'd14;
        end
      endcase
    end else if (ctl.kx_run) begin
      kx_i <= kx_i + 6'd1;
      kx_j <= (kx_j == nk_m1) ? 3'd0 : kx_j + 3'd1;
      if (kx_i > {3'b000, nk_m1} && kx_j == 3'd0) begin
        rc <= xtime(rc);
      end
      win[0] <= kx_word;
      for (int k = 1; k < 8; k++) begin
        win[k] <= win[k-1];
      end
      if (kx_i[1:0] != 2'b11) begin
        grp[kx_i[1:0]] <= kx_word;
      end
    end else if (enc_done && !abort) begin
      ctr <= ctr + 128'd1;
    end
    if (ctl.enc_run) begin
      blk <= (enc_rnd == 4'd0) ? (ctr ^ rk_rdata) : ks_new;
    end
  end

endmodule

/* sv/aesctr_checker.sv */
`timescale 1ns / 1ps
// port-level checker for the ctr-mode cipher, bound to the top level
// depends on aesctr_pkg and assert_macros.svh
`include "assert_macros.svh"

module aesctr_checker import aesctr_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // requests accepted but not yet delivered
  logic [7:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'((in_valid && in_ready) ? 1 : 0)
                         - 8'((out_valid && out_ready) ? 1 : 0);
    end
  end

  `AC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "output changed under stall")
  `AC_ASSERT_ALWAYS(a_out_reset, rst |=> !out_valid, "output valid right after reset")
  `AC_ASSERT(a_no_invented, out_valid |-> pending != 8'd0, "result without a pending request")
  `AC_ASSERT(a_ready_empty, pending == 8'd0 |-> in_ready, "not ready while empty")

endmodule

bind aes_ctr_stream_cipher_top aesctr_checker u_checker (.*);

/* verif/aes_ctr_keystream_checker.sv */
`timescale 1ns / 1ps
// checker for the ctr-mode cipher: tracks register writes, predicts each output byte
// from its own aes key schedule and block encryption, and compares in order
// depends on aesctr_pkg for the channel types, register indexes and the s-box table
module aes_ctr_keystream_checker import aesctr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  logic [1:0]   key_size_reg;
  logic [63:0]  key_reg [4];
  logic [127:0] iv_reg;

  logic [127:0] round_keys [15];
  int           num_rounds;
  logic [127:0] counter_blk;
  logic [127:0] keystream_blk;
  int           ks_pos;
  bit           msg_open;
  out_item_t    expected_bytes [$];

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_bytes32(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  task automatic build_round_keys();
    logic [31:0]  w [60];
    logic [255:0] key;
    logic [31:0]  t;
    logic [7:0]   rc;
    int           nk;
    nk = (key_size_reg == KEY_128) ? 4 : (key_size_reg == KEY_192) ? 6 : 8;
    num_rounds = nk + 6;
    key = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
    rc = 8'h01;
    for (int i = 0; i < nk; i++) w[i] = key[255-32*i -: 32];
    for (int i = nk; i < 4 * (num_rounds + 1); i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = sub_bytes32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_double(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_bytes32(t);
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int r = 0; r <= num_rounds; r++)
      round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  function automatic logic [127:0] encrypt_counter(input logic [127:0] blk);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, x;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ round_keys[0][127-8*i -: 8];
    for (int r = 1; r <= num_rounds; r++) begin
      // substitution and row shift in one pass
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[4*c+i] = SBOX[s[4*((c+i)%4)+i]];
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c];
        a1 = t[4*c+1];
        a2 = t[4*c+2];
        a3 = t[4*c+3];
        if (r != num_rounds) begin
          x = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ x ^ gf_double(a0 ^ a1);
          s[4*c+1] = a1 ^ x ^ gf_double(a1 ^ a2);
          s[4*c+2] = a2 ^ x ^ gf_double(a2 ^ a3);
          s[4*c+3] = a3 ^ x ^ gf_double(a3 ^ a0);
        end else begin
          s[4*c] = a0;
          s[4*c+1] = a1;
          s[4*c+2] = a2;
          s[4*c+3] = a3;
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= round_keys[r][127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  task automatic predict_byte(input in_item_t req);
    out_item_t exp_item;
    if (!msg_open) begin
      build_round_keys();
      counter_blk = iv_reg;
      ks_pos = 0;
      msg_open = 1;
    end
    if (ks_pos == 0) keystream_blk = encrypt_counter(counter_blk);
    exp_item.data_out = req.data_in ^ keystream_blk[127-8*ks_pos -: 8];
    exp_item.last_out = req.last_in;
    expected_bytes.push_back(exp_item);
    ks_pos++;
    if (ks_pos >= BLOCK_BYTES) begin
      ks_pos = 0;
      counter_blk = counter_blk + 128'd1;
    end
    if (req.last_in) begin
      msg_open = 0;
      ks_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      key_size_reg = KEY_128;
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      iv_reg = '0;
      msg_open = 0;
      ks_pos = 0;
      keystream_blk = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_SIZE: key_size_reg = cfg_data[1:0];
          REG_KEY_WORD0: key_reg[0] = cfg_data;
          REG_KEY_WORD1: key_reg[1] = cfg_data;
          REG_KEY_WORD2: key_reg[2] = cfg_data;
          REG_KEY_WORD3: key_reg[3] = cfg_data;
          REG_IV_HIGH: iv_reg[127:64] = cfg_data;
          REG_IV_LOW: iv_reg[63:0] = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected output byte %02h last %0b", out_data.data_out,
                     out_data.last_out);
        end else begin
          want = expected_bytes.pop_front();
          if (want.data_out !== out_data.data_out || want.last_out !== out_data.last_out) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       want.data_out, want.last_out, out_data.data_out, out_data.last_out);
          end
        end
      end
      if (in_valid && in_ready) predict_byte(in_data);
    end
    pending = expected_bytes.size();
  end

endmodule

/* verif/aes_ctr_stream_cipher_top_tb.sv */
`timescale 1ns / 1ps
// stimulus and verdict for the ctr-mode cipher: directed edge cases, then random
// messages over several key sizes, keys and counters; checking lives in the checker
// depends on aesctr_pkg, aes_ctr_stream_cipher_top and aes_ctr_keystream_checker
module aes_ctr_stream_cipher_top_tb;
  import aesctr_pkg::*;

  localparam logic [1:0] KEY_256 = 2'd2;
  localparam logic [1:0] KEY_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 235;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  in_valid = 0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 0;
  out_item_t             out_data;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors;
  int                    pending;

  bit idle_en = 1;
  int hold_reqs = 0;
  int hold_done = 0;
  int cycles = 0;

  aes_ctr_stream_cipher_top uut (.*);

  aes_ctr_keystream_checker checker_i (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver side: random stalls plus long hold-offs on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_reqs > hold_done) begin
        out_ready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end
      out_ready <= !(idle_en && $urandom_range(0, 99) < 19);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic setup_cipher(input logic [1:0] ksize, input logic [255:0] key,
                              input logic [127:0] iv);
    write_reg(REG_KEY_SIZE, {62'd0, ksize});
    write_reg(REG_KEY_WORD0, key[255:192]);
    write_reg(REG_KEY_WORD1, key[191:128]);
    write_reg(REG_KEY_WORD2, key[127:64]);
    write_reg(REG_KEY_WORD3, key[63:0]);
    write_reg(REG_IV_HIGH, iv[127:64]);
    write_reg(REG_IV_LOW, iv[63:0]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    // random idle gap before each byte while idle_en is set; each further idle cycle comes with the same odds
    while (idle_en && $urandom_range(0, 99) < 19) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{data_in: b, last_in: last};
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [255:0] key;
    logic [127:0] iv;
    int sent, len;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // counter at all ones wraps inside the first message
    setup_cipher(KEY_128, {256{1'b1}}, {128{1'b1}});
    send_byte(8'h00, 0);
    send_byte(8'hff, 0);
    send_byte(8'haa, 0);
    send_byte(8'h55, 0);
    for (int i = 4; i < 17; i++) send_byte(8'($urandom()), 0);
    send_byte(8'h3c, 1);
    send_byte(8'hff, 1);
    drain();
    // reserved key size runs as 256-bit, unmapped index must be ignored
    setup_cipher(KEY_RESERVED, '0, '0);
    write_reg(REG_UNMAPPED, {64{1'b1}});
    send_byte(8'h01, 0);
    send_byte(8'h80, 0);
    send_byte(8'hfe, 1);
    drain();

    for (int p = 0; p < 8; p++) begin
      key = {rand64(), rand64(), rand64(), rand64()};
      if (p == 1) key = '0;
      if (p == 2) key = {256{1'b1}};
      iv = {rand64(), rand64()};
      if (p % 3 == 1) iv[63:0] = ~64'($urandom_range(0, 40));
      if (p == 2) iv = ~128'($urandom_range(0, 40));
      setup_cipher(p[1:0], key, iv);
      idle_en = (p != 3);
      if (p == 5) hold_reqs++;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 35);
        if (sent + len > PHASE_BYTES) len = PHASE_BYTES - sent;
        for (int i = 0; i < len; i++) send_byte(8'($urandom()), i == len - 1);
        sent += len;
        if (p == 6 && sent > PHASE_BYTES / 2 && sent - len <= PHASE_BYTES / 2) drain();
      end
      drain();
      idle_en = 1;
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
